// ===== sv/assert_macros.svh =====
// Assertion macros shared by the json string unescaper RTL.
// Each macro expands to one labeled concurrent assertion on a given clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/jsu_pkg.sv =====
// Package for the json string unescaper: result kinds, job descriptor, byte codes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_END  = 2'd1,
    TAIL_ERR  = 2'd2
  } tail_t;

  // Work for the back end: up to three decoded bytes, then an optional end or error.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    tail_t           tail;
  } job_t;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;

  localparam logic [7:0] BYTE_TAB  = 8'h09;
  localparam logic [7:0] BYTE_BS   = 8'h08;
  localparam logic [7:0] BYTE_FF   = 8'h0c;
  localparam logic [7:0] BYTE_CR   = 8'h0d;
  localparam logic [7:0] BYTE_LF   = 8'h0a;

  localparam logic [15:0] UTF8_LIM1 = 16'h0080;
  localparam logic [15:0] UTF8_LIM2 = 16'h0800;
  localparam logic [7:0]  UTF8_CONT = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'he0;

  function automatic job_t utf8_job(input logic [15:0] code);
    job_t j;
    j = '0;
    j.tail = TAIL_NONE;
    if (code == 16'd0) begin
      j.nbytes = 2'd0;
    end else if (code < UTF8_LIM1) begin
      j.bytes[0] = code[7:0];
      j.nbytes   = 2'd1;
    end else if (code < UTF8_LIM2) begin
      j.bytes[0] = UTF8_LEAD2 | {3'b000, code[10:6]};
      j.bytes[1] = UTF8_CONT | {2'b00, code[5:0]};
      j.nbytes   = 2'd2;
    end else begin
      j.bytes[0] = UTF8_LEAD3 | {4'b0000, code[15:12]};
      j.bytes[1] = UTF8_CONT | {2'b00, code[11:6]};
      j.bytes[2] = UTF8_CONT | {2'b00, code[5:0]};
      j.nbytes   = 2'd3;
    end
    return j;
  endfunction

endpackage

// ===== sv/jsu_front.sv =====
// Front end of the json string unescaper: escape and \u state, classifies each byte
// into a job for the back end. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    in_byte,
  input  logic          in_text_end,
  output logic          push,
  output jsu_pkg::job_t job
);

  logic        esc_r,  esc_nxt;
  logic        hex_r,  hex_nxt;
  logic [1:0]  cnt_r,  cnt_nxt;
  logic [11:0] code_r, code_nxt;

  logic [3:0]  hv;
  logic [15:0] acc;
  logic        ended;
  logic        abort;

  always_comb begin
    hv       = (in_byte <= jsu_pkg::CH_DIGIT9) ? in_byte[3:0]
                                               : ({1'b0, in_byte[2:0]} + 4'd9);
    acc      = {code_r, hv};
    esc_nxt  = esc_r;
    hex_nxt  = hex_r;
    cnt_nxt  = cnt_r;
    code_nxt = code_r;
    job      = '0;
    job.tail = jsu_pkg::TAIL_NONE;
    ended    = 1'b0;
    abort    = 1'b0;

    if (hex_r) begin
      code_nxt = acc[11:0];
      if (cnt_r == 2'd3) begin
        job      = jsu_pkg::utf8_job(acc);
        hex_nxt  = 1'b0;
        cnt_nxt  = 2'd0;
        code_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 2'd1;
        abort   = in_text_end;
      end
    end else if (esc_r) begin
      esc_nxt    = 1'b0;
      job.nbytes = 2'd1;
      unique case (in_byte)
        jsu_pkg::CH_BSLASH: job.bytes[0] = jsu_pkg::CH_BSLASH;
        jsu_pkg::CH_QUOTE:  job.bytes[0] = jsu_pkg::CH_QUOTE;
        jsu_pkg::CH_T:      job.bytes[0] = jsu_pkg::BYTE_TAB;
        jsu_pkg::CH_B:      job.bytes[0] = jsu_pkg::BYTE_BS;
        jsu_pkg::CH_F:      job.bytes[0] = jsu_pkg::BYTE_FF;
        jsu_pkg::CH_R:      job.bytes[0] = jsu_pkg::BYTE_CR;
        jsu_pkg::CH_N:      job.bytes[0] = jsu_pkg::BYTE_LF;
        jsu_pkg::CH_U: begin
          job.nbytes = 2'd0;
          abort      = in_text_end;
          hex_nxt    = 1'b1;
          cnt_nxt    = 2'd0;
          code_nxt   = '0;
        end
        default:            job.bytes[0] = in_byte;
      endcase
    end else if (in_byte == jsu_pkg::CH_BSLASH) begin
      esc_nxt = 1'b1;
    end else if (in_byte == jsu_pkg::CH_QUOTE) begin
      job.tail = jsu_pkg::TAIL_END;
      ended    = 1'b1;
    end else begin
      job.bytes[0] = in_byte;
      job.nbytes   = 2'd1;
    end

    // A truncated \u escape reports only the error; any other text end closes the string.
    if (abort) begin
      job.nbytes = 2'd0;
      job.tail   = jsu_pkg::TAIL_ERR;
    end else if (in_text_end) begin
      job.tail = jsu_pkg::TAIL_END;
    end
    if (abort || in_text_end || ended) begin
      esc_nxt  = 1'b0;
      hex_nxt  = 1'b0;
      cnt_nxt  = 2'd0;
      code_nxt = '0;
    end
  end

  assign push = fire && ((job.nbytes != 2'd0) || (job.tail != jsu_pkg::TAIL_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= 1'b0;
      hex_r  <= 1'b0;
      cnt_r  <= 2'd0;
      code_r <= '0;
    end else if (fire) begin
      esc_r  <= esc_nxt;
      hex_r  <= hex_nxt;
      cnt_r  <= cnt_nxt;
      code_r <= code_nxt;
    end
  end

endmodule

// ===== sv/jsu_queue.sv =====
// Two-entry job queue between the front and back ends of the json string unescaper.
// Depends on jsu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  output logic          full,
  output logic          q_valid,
  output jsu_pkg::job_t q_job,
  input  logic          pop
);

  jsu_pkg::job_t slots_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r,    cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, q_valid)
  `ASSERT_NEXT(a_push_alone_grows, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 2'd1)

endmodule

// ===== sv/jsu_back.sv =====
// Back end of the json string unescaper: walks the head job, one result per cycle
// unless stalled, into the output register. Depends on jsu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  jsu_pkg::job_t q_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_result_kind,
  output logic          out_run_last
);

  logic [1:0]     step_r, step_nxt;
  logic           vld_r,  vld_nxt;
  logic [7:0]     byte_r;
  jsu_pkg::kind_t kind_r;
  logic           last_r;

  logic [2:0]     total;
  logic           is_last;
  logic           load;
  logic [7:0]     cur_byte;
  jsu_pkg::kind_t cur_kind;

  always_comb begin
    total    = {1'b0, q_job.nbytes} + {2'b00, (q_job.tail != jsu_pkg::TAIL_NONE)};
    is_last  = ({1'b0, step_r} == (total - 3'd1));
    load     = q_valid && (!vld_r || out_ready);
    cur_byte = '0;
    cur_kind = jsu_pkg::KIND_BYTE;
    if (step_r < q_job.nbytes) begin
      unique case (step_r)
        2'd0:    cur_byte = q_job.bytes[0];
        2'd1:    cur_byte = q_job.bytes[1];
        default: cur_byte = q_job.bytes[2];
      endcase
    end else if (q_job.tail == jsu_pkg::TAIL_ERR) begin
      cur_kind = jsu_pkg::KIND_ERR;
    end else begin
      cur_kind = jsu_pkg::KIND_END;
    end
    pop      = load && is_last;
    step_nxt = load ? (is_last ? 2'd0 : step_r + 2'd1) : step_r;
    vld_nxt  = load ? 1'b1 : (vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      vld_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      kind_r <= cur_kind;
      last_r <= is_last;
    end
  end

  assign out_valid       = vld_r;
  assign out_byte        = byte_r;
  assign out_result_kind = kind_r;
  assign out_run_last    = last_r;

  `ASSERT_IMPLIES(a_step_in_job, clk, rst_n, q_valid, {1'b0, step_r} < total)
  `ASSERT_IMPLIES(a_head_held_mid_job, clk, rst_n, step_r != 2'd0, q_valid)
  `ASSERT_IMPLIES(a_error_alone, clk, rst_n, q_valid && (q_job.tail == jsu_pkg::TAIL_ERR),
                  q_job.nbytes == 2'd0)

endmodule

// ===== sv/json_string_unescape_utf8.sv =====
// JSON string body unescaper with UTF-8 encoding of \uXXXX escapes.
// Input channel (in_valid/in_ready): one raw byte of the string body per transfer,
// starting after the opening quote, with in_text_end marking the last byte of the text.
// Output channel (out_valid/out_ready): one result per transfer: a decoded byte, an end
// of string, or a truncated-\u error; out_run_last flags the last result of an input.
// An input byte yields zero to four results; bytes that yield none (backslash, 'u',
// partial hex digits, a \u0000) are absorbed.
// A result passes from its input transfer through a queue slot to the output register.
// Throughput: one input per cycle while each yields one result and out_ready is high;
// a multi-result input holds the back end until the single output register emits all.
// A two-entry job queue separates the classifier from the output sequencer, so input
// keeps flowing while a result waits; in_ready drops only when that queue is full.
// Reset (rst_n low, synchronous) clears the escape state, the queue and the output.
// When the receiver stalls, the output holds its result and the queue fills, then
// in_ready falls until results drain.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
`timescale 1ns / 1ps

module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_text_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_result_kind,
  output logic       out_run_last
);

  logic          fire;
  logic          push;
  logic          full;
  logic          q_valid;
  logic          pop;
  jsu_pkg::job_t push_job;
  jsu_pkg::job_t q_job;

  assign in_ready = !full;
  assign fire     = in_valid && in_ready;

  jsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .in_byte     (in_byte),
    .in_text_end (in_text_end),
    .push        (push),
    .job         (push_job)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop)
  );

  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (q_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_result_kind (out_result_kind),
    .out_run_last    (out_run_last)
  );

endmodule
